// ===== src/bpa_pkg.sv =====
// Shared types, constants and helpers for the buddy page allocator.
// Has no dependencies; imported by buddy_page_allocator_core.
`default_nettype none
package bpa_pkg;
    localparam int POOL_PAGES = 1024;
    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int CNT_W = PAGE_W + 1;
    localparam int ORD_W = $clog2(PAGE_W + 1);
    localparam int ENTRY_W = ORD_W + 2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    typedef struct packed {
        logic              head;
        logic              free;
        logic [ORD_W-1:0]  ord;
    } t_entry;

    function automatic logic [ORD_W-1:0] pool_log(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] c;
        logic [ORD_W-1:0] lg;
        c = (n > CNT_W'(POOL_PAGES)) ? CNT_W'(POOL_PAGES) : n;
        lg = '0;
        for (int j = 0; j < CNT_W; j++) begin
            if (c[j]) begin
                lg = ORD_W'(j);
            end
        end
        return lg;
    endfunction

    function automatic logic [CNT_W-1:0] pool_size(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] s;
        s = (n == '0) ? '0 : (CNT_W'(1) << pool_log(n));
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== src/bpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/buddy_page_allocator_core.sv =====
// Buddy page allocator top level: sequencer around the page table memory.
// Depends on bpa_pkg and bpa_ram.
//
// A request (i_cmd, i_count, i_page) is taken at a clock edge where start is
// high and busy is low. Exactly one result follows unless a configuration
// write comes first: o_done is high for one cycle with o_status,
// o_block_start, o_block_size and o_free_total. The receiver cannot stall;
// each result is shown once. Errors that are detected up front return in
// the cycle after the request. An allocate walks the page table one block
// head per cycle, then splits one level per cycle. A free walks back one
// page per cycle to the block head, then merges each level by reading the
// buddy, checking it, clearing the upper head and writing the merged head.
// The single read port of the page table paces these walks.
// Reset, and every write on the configuration channel, starts a clearing
// pass over all 1024 page table entries during which busy is high.
// Configuration writes are always ready.
`default_nettype none
module buddy_page_allocator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cmd,
    input  wire logic [bpa_pkg::CNT_W-1:0]   i_count,
    input  wire logic [bpa_pkg::PAGE_W-1:0]  i_page,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bpa_pkg::CNT_W-1:0]   i_cfg_pool_pages,
    output logic                             o_done,
    output logic      [1:0]                  o_status,
    output logic      [bpa_pkg::PAGE_W-1:0]  o_block_start,
    output logic      [bpa_pkg::CNT_W-1:0]   o_block_size,
    output logic      [bpa_pkg::CNT_W-1:0]   o_free_total
);
    import bpa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_ASCAN = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_FSCAN = 3'd4;
    localparam logic [2:0] S_MRD   = 3'd5;
    localparam logic [2:0] S_MCHK  = 3'd6;
    localparam logic [2:0] S_MWR   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [PAGE_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]  r_pool_size, n_pool_size;
    logic [ORD_W-1:0]  r_pool_log, n_pool_log;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_size, n_size;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [PAGE_W-1:0] r_bstart, n_bstart;
    logic [CNT_W-1:0]  r_bsize, n_bsize;
    logic              r_done, n_done;
    logic [1:0]        r_status, n_status;
    logic [PAGE_W-1:0] r_ostart, n_ostart;
    logic [CNT_W-1:0]  r_osize, n_osize;

    logic              ram_we;
    logic [PAGE_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_rdata;

    t_entry            e;
    logic [CNT_W-1:0]  bs;
    logic [CNT_W-1:0]  buddy;
    logic [PAGE_W-1:0] rel;

    bpa_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_PAGES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign e     = ram_rdata;
    assign bs    = CNT_W'(1) << e.ord;
    assign buddy = r_i ^ r_size;
    assign rel   = r_page - r_i[PAGE_W-1:0];

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_pool_size = r_pool_size;
        n_pool_log = r_pool_log;
        n_free = r_free;
        n_i = r_i;
        n_k = r_k;
        n_size = r_size;
        n_count = r_count;
        n_page = r_page;
        n_bstart = r_bstart;
        n_bsize = r_bsize;
        n_done = 1'b0;
        n_status = r_status;
        n_ostart = r_ostart;
        n_osize = r_osize;
        ram_we = 1'b0;
        ram_waddr = r_i[PAGE_W-1:0];
        ram_wdata = '0;
        ram_raddr = r_i[PAGE_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_count = i_count;
                    n_page = i_page;
                    n_done = 1'b1;
                    n_ostart = '0;
                    n_osize = '0;
                    if (i_count == '0) begin
                        n_status = ST_INVALID;
                    end else if (i_cmd == CMD_ALLOC) begin
                        if (i_count > r_free) begin
                            n_status = ST_NOSPACE;
                        end else begin
                            n_done = 1'b0;
                            n_i = '0;
                            ram_raddr = '0;
                            n_state = S_ASCAN;
                        end
                    end else if (CNT_W'(i_page) >= r_pool_size) begin
                        n_status = ST_INVALID;
                    end else begin
                        n_done = 1'b0;
                        n_i = CNT_W'(i_page);
                        ram_raddr = i_page;
                        n_state = S_FSCAN;
                    end
                end
            end
            S_CLR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == '0 && r_pool_size != '0) begin
                    ram_wdata = '{head: 1'b1, free: 1'b1, ord: r_pool_log};
                end
                n_clr = r_clr + PAGE_W'(1);
                if (r_clr == PAGE_W'(POOL_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_ASCAN: begin
                if (r_i >= r_pool_size) begin
                    n_done = 1'b1;
                    n_status = ST_NOSPACE;
                    n_ostart = '0;
                    n_osize = '0;
                    n_state = S_IDLE;
                end else if (e.head) begin
                    if (e.free && bs >= r_count) begin
                        n_k = e.ord;
                        n_size = bs;
                        n_state = S_SPLIT;
                    end else begin
                        n_i = r_i + bs;
                    end
                end else begin
                    n_i = r_i + CNT_W'(1);
                end
                ram_raddr = n_i[PAGE_W-1:0];
            end
            S_SPLIT: begin
                ram_we = 1'b1;
                if ((r_size >> 1) >= r_count && r_k != '0) begin
                    n_size = r_size >> 1;
                    n_k = r_k - ORD_W'(1);
                    ram_waddr = r_i[PAGE_W-1:0] + n_size[PAGE_W-1:0];
                    ram_wdata = '{head: 1'b1, free: 1'b1, ord: n_k};
                end else begin
                    ram_wdata = '{head: 1'b1, free: 1'b0, ord: r_k};
                    n_free = r_free - r_size;
                    n_done = 1'b1;
                    n_status = ST_DONE;
                    n_ostart = r_i[PAGE_W-1:0];
                    n_osize = r_size;
                    n_state = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (e.head || r_i == '0) begin
                    if (e.free || ({1'b0, CNT_W'(rel)} + {1'b0, r_count}) > {1'b0, bs}) begin
                        n_done = 1'b1;
                        n_status = ST_INVALID;
                        n_ostart = '0;
                        n_osize = '0;
                        n_state = S_IDLE;
                    end else begin
                        ram_we = 1'b1;
                        ram_wdata = '{head: 1'b1, free: 1'b1, ord: e.ord};
                        n_free = r_free + bs;
                        n_k = e.ord;
                        n_size = bs;
                        n_bstart = r_i[PAGE_W-1:0];
                        n_bsize = bs;
                        n_state = S_MRD;
                    end
                end else begin
                    n_i = r_i - CNT_W'(1);
                    ram_raddr = n_i[PAGE_W-1:0];
                end
            end
            S_MRD: begin
                ram_raddr = buddy[PAGE_W-1:0];
                if (r_k >= r_pool_log || buddy >= r_pool_size) begin
                    n_done = 1'b1;
                    n_status = ST_DONE;
                    n_ostart = r_bstart;
                    n_osize = r_bsize;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                if (e.head && e.free && e.ord == r_k) begin
                    ram_we = 1'b1;
                    if (buddy < r_i) begin
                        ram_waddr = r_i[PAGE_W-1:0];
                        n_i = buddy;
                    end else begin
                        ram_waddr = buddy[PAGE_W-1:0];
                    end
                    n_k = r_k + ORD_W'(1);
                    n_size = r_size << 1;
                    n_state = S_MWR;
                end else begin
                    n_done = 1'b1;
                    n_status = ST_DONE;
                    n_ostart = r_bstart;
                    n_osize = r_bsize;
                    n_state = S_IDLE;
                end
            end
            S_MWR: begin
                ram_we = 1'b1;
                ram_wdata = '{head: 1'b1, free: 1'b1, ord: r_k};
                n_state = S_MRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_pool_size = pool_size(i_cfg_pool_pages);
            n_pool_log = pool_log(i_cfg_pool_pages);
            n_free = n_pool_size;
            n_clr = '0;
            n_done = 1'b0;
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_pool_size <= pool_size(CNT_W'(POOL_PAGES));
            r_pool_log <= pool_log(CNT_W'(POOL_PAGES));
            r_free <= pool_size(CNT_W'(POOL_PAGES));
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_pool_size <= n_pool_size;
            r_pool_log <= n_pool_log;
            r_free <= n_free;
            r_done <= n_done;
        end
        r_i <= n_i;
        r_k <= n_k;
        r_size <= n_size;
        r_count <= n_count;
        r_page <= n_page;
        r_bstart <= n_bstart;
        r_bsize <= n_bsize;
        r_status <= n_status;
        r_ostart <= n_ostart;
        r_osize <= n_osize;
    end

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done = r_done;
    assign o_status = r_status;
    assign o_block_start = r_ostart;
    assign o_block_size = r_osize;
    assign o_free_total = r_free;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe raised while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid && i_count != '0 && i_cmd == CMD_FREE
         && CNT_W'(i_page) < r_pool_size) |=> busy)
        else $error("accepted free did not raise busy");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_pool_size) else $error("free total exceeds pool size");
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_state == S_CLR && r_clr == '0))
        else $error("configuration write did not restart clearing");
endmodule
`default_nettype wire
